// ----- hdl/smbs_pkg.sv -----
// Shared types and constants for the sensorless mode blend selector.
// No dependencies; used by the top level, its port checker and the testbench.
`timescale 1ns / 1ps

package smbs_pkg;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_INJ  = 2'd0;
    localparam mode_t MODE_MIX  = 2'd1;
    localparam mode_t MODE_FLUX = 2'd2;

    typedef logic [1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_LOW_SPEED  = 2'd0;
    localparam cfg_idx_t CFG_HIGH_SPEED = 2'd1;
    localparam cfg_idx_t CFG_DEBOUNCE   = 2'd2;
    localparam cfg_idx_t CFG_SETTLE     = 2'd3;

    localparam int THR_BITS  = 31;
    localparam int CNT_BITS  = 8;
    localparam int RATIO_BITS = 16;
    localparam int FRAC_BITS = 15;

    localparam logic [THR_BITS-1:0] LOW_SPEED_RESET  = 31'd5242880;
    localparam logic [THR_BITS-1:0] HIGH_SPEED_RESET = 31'd7864320;
    localparam logic [CNT_BITS-1:0] DEBOUNCE_RESET   = 8'd100;
    localparam logic [CNT_BITS-1:0] SETTLE_RESET     = 8'd100;
    localparam logic [CNT_BITS-1:0] CNT_MAX          = 8'd255;

    localparam logic [RATIO_BITS-1:0] RATIO_ZERO = 16'd0;
    localparam logic [RATIO_BITS-1:0] RATIO_ONE  = 16'd32768;
    localparam logic [RATIO_BITS-1:0] RATIO_HALF = 16'd16384;
    localparam int ROUND_HALF = 16384;

    // One quotient bit per divider step.
    localparam int DIV_STEPS = FRAC_BITS;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MAG   = 6'b000010,
        ST_MODE  = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_MUL   = 6'b010000,
        ST_BLEND = 6'b100000
    } state_t;

endpackage

// ----- hdl/sensorless_mode_blend_selector_top.sv -----
// Top level of the sensorless mode blend selector: mode sequencer, shared
// restoring divider step and blend multiplier. Depends on smbs_pkg.
`timescale 1ns / 1ps

// Usage
// One input beat per control period carries the injection PLL and flux
// observer estimates on s_tdata. The block answers with exactly one result
// beat on m_tdata: the active mode, the rotor angle to use, the flux blend
// ratio and three control flags. Thresholds and limits are to be written by
// the user through the cfg_wr_en / cfg_addr / cfg_wdata port only while no
// beat is in flight; the block does not enforce it. After the accepting edge
// the beat passes the magnitude, mode, multiply and blend states in turn,
// with the divide state between mode and multiply when the blend ratio has
// to be divided out. The divider gives one quotient bit per cycle, one per
// fraction bit. s_tready is high only while the sequencer is idle, so one
// beat is worked on at a time: a new beat can be taken in the cycle after
// the previous result was loaded. The result sits in an output register. If
// the receiver stalls, the next item is still accepted and computed, and it
// waits in its last step until the output register is free.
// Reset (aresetn low at a rising edge) restores the default thresholds and
// limits, puts the selector in injection mode with cleared counters and
// drops m_tvalid.
module sensorless_mode_blend_selector_top #(
    parameter int ANGLE_BITS = 16,
    parameter int SPEED_BITS = 32
) (
    input  logic aclk,
    input  logic aresetn,

    // Fields from bit 0 up: hfi_speed, flux_speed, hfi_angle, flux_angle.
    input  logic [((2*SPEED_BITS+2*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic s_tvalid,
    output logic s_tready,

    // Fields from bit 0 up: active mode, rotor_angle, blend_ratio,
    // use_fundamental, inject_enable, pll_reload.
    output logic [((ANGLE_BITS+21+7)/8)*8-1:0] m_tdata,
    output logic m_tvalid,
    input  logic m_tready,

    input  logic                             cfg_wr_en,
    input  smbs_pkg::cfg_idx_t               cfg_addr,
    input  logic [smbs_pkg::THR_BITS-1:0]    cfg_wdata
);
    import smbs_pkg::*;

    localparam int OUT_W  = ANGLE_BITS + 21;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
    // Compare width for speed magnitudes against the 31-bit thresholds.
    localparam int CMP_W  = (SPEED_BITS > THR_BITS) ? SPEED_BITS : THR_BITS;
    localparam int PROD_W = ANGLE_BITS + 18;
    localparam int DCNT_W = $clog2(DIV_STEPS);

    // Configuration registers.
    logic [THR_BITS-1:0] low_thr_reg, high_thr_reg;
    logic [CNT_BITS-1:0] debounce_reg, settle_lim_reg;

    // Selector state.
    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [CNT_BITS-1:0] trans_cnt_reg, trans_cnt_next;
    logic [CNT_BITS-1:0] settle_cnt_reg, settle_cnt_next;
    logic [DCNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                m_valid_reg, m_valid_next;

    // Working payload.
    logic [SPEED_BITS-1:0]        hfi_spd_reg, flux_spd_reg, spd_reg;
    logic [ANGLE_BITS-1:0]        hfi_ang_reg, flux_ang_reg;
    logic signed [ANGLE_BITS:0]   diff_reg;
    logic                         reload_reg;
    logic [RATIO_BITS-1:0]        ratio_reg;
    logic [THR_BITS-1:0]          rem_reg, dvs_reg;
    logic [FRAC_BITS-1:0]         quot_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic [OUT_TW-1:0]            m_data_reg;

    logic in_beat, out_free;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Magnitude and minimum of the two speeds.
    logic [SPEED_BITS-1:0] hfi_mag, flux_mag, spd_min;
    assign hfi_mag  = hfi_spd_reg[SPEED_BITS-1] ? (~hfi_spd_reg + 1'b1) : hfi_spd_reg;
    assign flux_mag = flux_spd_reg[SPEED_BITS-1] ? (~flux_spd_reg + 1'b1) : flux_spd_reg;
    assign spd_min  = (hfi_mag < flux_mag) ? hfi_mag : flux_mag;

    logic signed [ANGLE_BITS:0] ang_diff;
    assign ang_diff = $signed({flux_ang_reg[ANGLE_BITS-1], flux_ang_reg})
                    - $signed({hfi_ang_reg[ANGLE_BITS-1], hfi_ang_reg});

    // Threshold compares.
    logic [CMP_W-1:0] spd_ext, lo_ext, hi_ext, spd_minus_lo;
    logic gt_lo, lt_lo, gt_hi, lt_hi;
    assign spd_ext      = CMP_W'(spd_reg);
    assign lo_ext       = CMP_W'(low_thr_reg);
    assign hi_ext       = CMP_W'(high_thr_reg);
    assign spd_minus_lo = spd_ext - lo_ext;
    assign gt_lo = spd_ext > lo_ext;
    assign lt_lo = spd_ext < lo_ext;
    assign gt_hi = spd_ext > hi_ext;
    assign lt_hi = spd_ext < hi_ext;

    logic [CNT_BITS-1:0] tick_cnt, settle_eff;
    logic                fire, reload_now;
    assign tick_cnt = (trans_cnt_reg != CNT_MAX) ? trans_cnt_reg + 1'b1 : trans_cnt_reg;
    assign fire     = tick_cnt > debounce_reg;

    // Shared divider step: shift the remainder and try one subtraction.
    logic [THR_BITS:0]    rem_dbl;
    logic                 rem_ge;
    logic [THR_BITS-1:0]  rem_step;
    logic [FRAC_BITS-1:0] quot_step;
    assign rem_dbl   = {rem_reg, 1'b0};
    assign rem_ge    = rem_dbl >= {1'b0, dvs_reg};
    assign rem_step  = rem_ge ? THR_BITS'(rem_dbl - {1'b0, dvs_reg}) : rem_dbl[THR_BITS-1:0];
    assign quot_step = {quot_reg[FRAC_BITS-2:0], rem_ge};

    // Blend: angle = hfi + round((flux - hfi) * ratio / 2^15), wrapped.
    logic signed [PROD_W-1:0]     prod_next, rnd_sum, rnd_shift;
    logic signed [RATIO_BITS:0]   ratio_s;
    logic [ANGLE_BITS-1:0]        angle_out;
    assign ratio_s   = $signed({1'b0, ratio_reg});
    assign prod_next = diff_reg * ratio_s;
    assign rnd_sum   = prod_reg + PROD_W'(ROUND_HALF);
    assign rnd_shift = rnd_sum >>> FRAC_BITS;
    assign angle_out = hfi_ang_reg + rnd_shift[ANGLE_BITS-1:0];

    logic [OUT_W-1:0] result;
    assign result = {reload_reg,
                     (mode_reg == MODE_INJ) || (mode_reg == MODE_MIX),
                     ratio_reg < RATIO_HALF,
                     ratio_reg,
                     angle_out,
                     mode_reg};

    // Mode decision and sequencing.
    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        trans_cnt_next  = trans_cnt_reg;
        settle_cnt_next = settle_cnt_reg;
        div_cnt_next    = div_cnt_reg;
        m_valid_next    = m_valid_reg;
        reload_now      = 1'b0;
        settle_eff      = settle_cnt_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG: begin
                state_next = ST_MODE;
            end
            ST_MODE: begin
                // Debounced mode change first; the angle follows the new mode.
                unique case (mode_reg)
                    MODE_INJ: begin
                        if (gt_lo) begin
                            trans_cnt_next = tick_cnt;
                            if (fire) begin
                                mode_next      = MODE_MIX;
                                trans_cnt_next = '0;
                            end
                        end else begin
                            trans_cnt_next = '0;
                        end
                    end
                    MODE_MIX: begin
                        if (lt_lo || gt_hi) begin
                            trans_cnt_next = tick_cnt;
                            if (fire) begin
                                mode_next      = lt_lo ? MODE_INJ : MODE_FLUX;
                                trans_cnt_next = '0;
                            end
                        end else begin
                            trans_cnt_next = '0;
                        end
                    end
                    default: begin
                        if (lt_hi) begin
                            trans_cnt_next = tick_cnt;
                            if (fire) begin
                                mode_next      = MODE_MIX;
                                trans_cnt_next = '0;
                                reload_now     = 1'b1;
                            end
                        end else begin
                            trans_cnt_next = '0;
                        end
                    end
                endcase

                settle_eff      = reload_now ? '0 : settle_cnt_reg;
                settle_cnt_next = settle_eff;
                state_next      = ST_MUL;
                if (mode_next == MODE_MIX) begin
                    if (settle_eff < settle_lim_reg) begin
                        settle_cnt_next = settle_eff + 1'b1;
                    end else if (gt_lo && lt_hi) begin
                        state_next   = ST_DIV;
                        div_cnt_next = '0;
                    end
                end
            end
            ST_DIV: begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_INJ;
            trans_cnt_reg  <= '0;
            settle_cnt_reg <= '0;
            div_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
            low_thr_reg    <= LOW_SPEED_RESET;
            high_thr_reg   <= HIGH_SPEED_RESET;
            debounce_reg   <= DEBOUNCE_RESET;
            settle_lim_reg <= SETTLE_RESET;
        end else begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            trans_cnt_reg  <= trans_cnt_next;
            settle_cnt_reg <= settle_cnt_next;
            div_cnt_reg    <= div_cnt_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_LOW_SPEED:  low_thr_reg    <= cfg_wdata;
                    CFG_HIGH_SPEED: high_thr_reg   <= cfg_wdata;
                    CFG_DEBOUNCE:   debounce_reg   <= cfg_wdata[CNT_BITS-1:0];
                    CFG_SETTLE:     settle_lim_reg <= cfg_wdata[CNT_BITS-1:0];
                    default:        low_thr_reg    <= low_thr_reg;
                endcase
            end
        end
    end

    // Payload path.
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            hfi_spd_reg  <= s_tdata[SPEED_BITS-1:0];
            flux_spd_reg <= s_tdata[2*SPEED_BITS-1:SPEED_BITS];
            hfi_ang_reg  <= s_tdata[2*SPEED_BITS+ANGLE_BITS-1:2*SPEED_BITS];
            flux_ang_reg <= s_tdata[2*SPEED_BITS+2*ANGLE_BITS-1:2*SPEED_BITS+ANGLE_BITS];
        end
        if (state_reg == ST_MAG) begin
            spd_reg  <= spd_min;
            diff_reg <= ang_diff;
        end
        if (state_reg == ST_MODE) begin
            reload_reg <= reload_now;
            // On the reload period the PLL angle is taken from the observer.
            if (reload_now) begin
                hfi_ang_reg <= flux_ang_reg;
                diff_reg    <= '0;
            end
            rem_reg  <= spd_minus_lo[THR_BITS-1:0];
            dvs_reg  <= high_thr_reg - low_thr_reg;
            quot_reg <= '0;
            if (mode_next == MODE_INJ) begin
                ratio_reg <= RATIO_ZERO;
            end else if (mode_next == MODE_MIX) begin
                if (settle_eff < settle_lim_reg || !gt_lo) begin
                    ratio_reg <= RATIO_ZERO;
                end else begin
                    ratio_reg <= RATIO_ONE;
                end
            end else begin
                ratio_reg <= RATIO_ONE;
            end
        end
        if (state_reg == ST_DIV) begin
            rem_reg  <= rem_step;
            quot_reg <= quot_step;
            if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                ratio_reg <= {1'b0, quot_step};
            end
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_BLEND && out_free) begin
            m_data_reg <= OUT_TW'(result);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- hdl/smbs_checker.sv -----
// Port-level checker for the sensorless mode blend selector, bound to the top.
// Depends on smbs_pkg and on the port list of sensorless_mode_blend_selector_top.
`timescale 1ns / 1ps

module smbs_checker #(
    parameter int ANGLE_BITS = 16
) (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic [((ANGLE_BITS+21+7)/8)*8-1:0] m_tdata,
    input logic m_tvalid,
    input logic m_tready
);
    import smbs_pkg::*;

    localparam int RATIO_LSB = ANGLE_BITS + 2;
    localparam int FUND_BIT  = ANGLE_BITS + 18;
    localparam int INJ_BIT   = ANGLE_BITS + 19;
    localparam int RLD_BIT   = ANGLE_BITS + 20;

    mode_t                 mode_f;
    logic [RATIO_BITS-1:0] ratio_f;
    assign mode_f  = m_tdata[1:0];
    assign ratio_f = m_tdata[RATIO_LSB+RATIO_BITS-1:RATIO_LSB];

    // A held result must not change or vanish.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // One item at a time: the block is busy after taking a beat.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while the previous one is in work");

    // A reload only comes with the change into mixed mode.
    a_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[RLD_BIT] |-> mode_f == MODE_MIX)
        else $error("reload outside mixed mode");

    // Flags agree with mode and ratio.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[INJ_BIT] == (mode_f != MODE_FLUX))
                  && (m_tdata[FUND_BIT] == (ratio_f < RATIO_HALF))
                  && (ratio_f <= RATIO_ONE))
        else $error("result flags inconsistent");

endmodule

bind sensorless_mode_blend_selector_top smbs_checker #(
    .ANGLE_BITS(ANGLE_BITS)
) u_smbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ----- sim/tb.sv -----
// Self-checking testbench for sensorless_mode_blend_selector_top: directed table, then
// random runs of speed bands under several threshold settings, checked against a model.
// Depends on smbs_pkg and the top level in hdl/.
`timescale 1ns / 1ps

module tb;
    import smbs_pkg::*;

    localparam int ANGLE_BITS = 16;
    localparam int SPEED_BITS = 32;
    localparam int S_WIDTH = ((2*SPEED_BITS+2*ANGLE_BITS+7)/8)*8;
    localparam int M_WIDTH = ((ANGLE_BITS+21+7)/8)*8;

    localparam longint unsigned SPEED_MAG_MAX = 64'd1 << (SPEED_BITS-1);
    localparam longint ANGLE_HALF = 64'sd1 << (ANGLE_BITS-1);
    localparam longint RATIO_SCALE = 64'sd1 << FRAC_BITS;

    // Handy Q16.16 speeds.
    localparam longint unsigned SPEED_50  = 64'd50 * 65536;
    localparam longint unsigned SPEED_80  = 64'd80 * 65536;
    localparam longint unsigned SPEED_90  = 64'd90 * 65536;
    localparam longint unsigned SPEED_100 = 64'd100 * 65536;
    localparam longint unsigned SPEED_110 = 64'd110 * 65536;
    localparam longint unsigned SPEED_120 = 64'd120 * 65536;
    localparam longint unsigned THR_MAX   = 64'h7FFF_FFFF;

    // Quiet time at the end, to catch a stray extra beat.
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 50;

    // How a random phase treats the two handshakes.
    localparam int STYLE_PLAIN  = 0;
    localparam int STYLE_HOLD   = 1;
    localparam int STYLE_STEADY = 2;

    // Speed bands that a run of beats sits in.
    localparam int BAND_BELOW_LOW = 0;
    localparam int BAND_BETWEEN   = 1;
    localparam int BAND_ABOVE_HI  = 2;
    localparam int BAND_AT_LOW    = 3;
    localparam int BAND_AT_HIGH   = 4;
    localparam int BAND_ANY       = 5;

    // Input beat, last field in the lowest bits.
    typedef struct packed {
        logic [ANGLE_BITS-1:0] flux_angle;
        logic [ANGLE_BITS-1:0] hfi_angle;
        logic [SPEED_BITS-1:0] flux_speed;
        logic [SPEED_BITS-1:0] hfi_speed;
    } sensor_beat_t;

    // Result beat, last field in the lowest bits.
    typedef struct packed {
        logic                  pll_reload;
        logic                  inject_enable;
        logic                  use_fundamental;
        logic [RATIO_BITS-1:0] blend_ratio;
        logic [ANGLE_BITS-1:0] rotor_angle;
        mode_t                 active_mode;
    } blend_result_t;

    typedef struct {
        sensor_beat_t  beat;
        bit            typed;
        blend_result_t want;
    } directed_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [S_WIDTH-1:0]    s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_WIDTH-1:0]    m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    cfg_idx_t              cfg_addr = CFG_LOW_SPEED;
    logic [THR_BITS-1:0]   cfg_wdata = '0;

    sensorless_mode_blend_selector_top #(
        .ANGLE_BITS(ANGLE_BITS),
        .SPEED_BITS(SPEED_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the selector: thresholds, limits, the mode and the two counters.
    longint unsigned thr_low      = LOW_SPEED_RESET;
    longint unsigned thr_high     = HIGH_SPEED_RESET;
    int unsigned     debounce_lim = DEBOUNCE_RESET;
    int unsigned     settle_lim   = SETTLE_RESET;
    mode_t           sel_mode     = MODE_INJ;
    int unsigned     qualify_count = 0;
    int unsigned     settle_count  = 0;

    blend_result_t   expected_results[$];
    directed_row_t   directed_table[$];

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;
    bit  hold_request = 1'b0;
    logic rx_hold = 1'b0;

    // One more qualifying period; the change fires once the count passes the
    // debounce limit. The count saturates, so a limit of 255 never fires.
    function automatic bit debounce_fires();
        if (qualify_count < CNT_MAX)
            qualify_count++;
        return qualify_count > debounce_lim;
    endfunction

    // The most negative speed has a magnitude one above the largest positive.
    function automatic longint unsigned speed_magnitude(logic [SPEED_BITS-1:0] raw);
        longint v;
        v = longint'($signed(raw));
        return (v < 0) ? -v : v;
    endfunction

    // Advance the shadow selector by one control period and build its result.
    function automatic blend_result_t predict_blend(sensor_beat_t b);
        longint unsigned spd_hfi, spd_flux, spd;
        longint          ang_hfi, ang_flux, ratio, mixed;
        bit              reload;
        blend_result_t   r;
        spd_hfi  = speed_magnitude(b.hfi_speed);
        spd_flux = speed_magnitude(b.flux_speed);
        spd      = (spd_hfi < spd_flux) ? spd_hfi : spd_flux;
        ang_hfi  = longint'($signed(b.hfi_angle));
        ang_flux = longint'($signed(b.flux_angle));
        reload   = 1'b0;
        ratio    = 0;

        // Mode first; the angle below comes from the new mode.
        if (sel_mode == MODE_INJ) begin
            if (spd > thr_low) begin
                if (debounce_fires()) begin
                    sel_mode = MODE_MIX;
                    qualify_count = 0;
                end
            end else begin
                qualify_count = 0;
            end
        end else if (sel_mode == MODE_MIX) begin
            if (spd < thr_low) begin
                if (debounce_fires()) begin
                    sel_mode = MODE_INJ;
                    qualify_count = 0;
                end
            end else if (spd > thr_high) begin
                if (debounce_fires()) begin
                    sel_mode = MODE_FLUX;
                    qualify_count = 0;
                end
            end else begin
                qualify_count = 0;
            end
        end else begin
            // Flux mode; the unused code 3 behaves the same way.
            if (spd < thr_high) begin
                if (debounce_fires()) begin
                    sel_mode = MODE_MIX;
                    settle_count = 0;
                    reload = 1'b1;
                    qualify_count = 0;
                end
            end else begin
                qualify_count = 0;
            end
        end

        // On the flux-to-mixed change the PLL is reloaded from the observer.
        if (reload)
            ang_hfi = ang_flux;

        if (sel_mode == MODE_INJ) begin
            mixed = ang_hfi;
        end else if (sel_mode == MODE_MIX) begin
            if (settle_count < settle_lim) begin
                mixed = ang_hfi;
                settle_count++;
            end else begin
                // Low test first, so high <= low never divides by zero.
                if (spd <= thr_low)
                    ratio = 0;
                else if (spd >= thr_high)
                    ratio = RATIO_SCALE;
                else
                    ratio = longint'(((spd - thr_low) << FRAC_BITS) / (thr_high - thr_low));
                mixed = ang_hfi * (RATIO_SCALE - ratio) + ang_flux * ratio;
                mixed = ((mixed + (ANGLE_HALF << FRAC_BITS) + ROUND_HALF) >>> FRAC_BITS)
                        - ANGLE_HALF;
            end
        end else begin
            mixed = ang_flux;
            ratio = RATIO_SCALE;
        end

        r.active_mode     = sel_mode;
        r.rotor_angle     = mixed[ANGLE_BITS-1:0];
        r.blend_ratio     = ratio[RATIO_BITS-1:0];
        r.use_fundamental = (ratio < RATIO_HALF);
        r.inject_enable   = (sel_mode == MODE_INJ) || (sel_mode == MODE_MIX);
        r.pll_reload      = reload;
        return r;
    endfunction

    function automatic directed_row_t dir_row(
        logic [SPEED_BITS-1:0] hs, logic [SPEED_BITS-1:0] fs,
        logic [ANGLE_BITS-1:0] ha, logic [ANGLE_BITS-1:0] fa,
        bit typed = 1'b0, mode_t md = MODE_INJ, logic [ANGLE_BITS-1:0] ang = '0,
        logic [RATIO_BITS-1:0] rat = '0, bit fund = 1'b0, bit inj = 1'b0, bit rel = 1'b0);
        directed_row_t row;
        row.beat.hfi_speed        = hs;
        row.beat.flux_speed       = fs;
        row.beat.hfi_angle        = ha;
        row.beat.flux_angle       = fa;
        row.typed                 = typed;
        row.want.active_mode      = md;
        row.want.rotor_angle      = ang;
        row.want.blend_ratio      = rat;
        row.want.use_fundamental  = fund;
        row.want.inject_enable    = inj;
        row.want.pll_reload       = rel;
        return row;
    endfunction

    // A magnitude in the requested band of the current thresholds (thr_low if empty).
    function automatic longint unsigned band_magnitude(int band);
        longint unsigned m, span;
        case (band)
            BAND_BELOW_LOW: begin
                if (thr_low == 0) begin
                    m = 0;
                end else if ($urandom_range(1)) begin
                    span = (thr_low - 1 < 4095) ? thr_low - 1 : 4095;
                    m = thr_low - 1 - $urandom_range(0, 32'(span));
                end else begin
                    m = $urandom_range(0, 32'(thr_low - 1));
                end
            end
            BAND_BETWEEN: begin
                if (thr_high > thr_low + 1)
                    m = thr_low + 1 + $urandom_range(0, 32'(thr_high - thr_low - 2));
                else
                    m = thr_low;
            end
            BAND_ABOVE_HI: m = thr_high + 1 + $urandom_range(0, 32'(SPEED_MAG_MAX - thr_high - 1));
            BAND_AT_LOW:   m = thr_low;
            BAND_AT_HIGH:  m = thr_high;
            default:       m = $urandom_range(0, 32'(SPEED_MAG_MAX));
        endcase
        return m;
    endfunction

    function automatic logic [SPEED_BITS-1:0] signed_speed(longint unsigned mag);
        logic [SPEED_BITS-1:0] v;
        if (mag >= SPEED_MAG_MAX)
            return {1'b1, {(SPEED_BITS-1){1'b0}}};
        v = mag[SPEED_BITS-1:0];
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] pick_angle();
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
                0:       return {1'b1, {(ANGLE_BITS-1){1'b0}}};
                1:       return {1'b0, {(ANGLE_BITS-1){1'b1}}};
                2:       return '0;
                default: return '1;
            endcase
        end
        return ANGLE_BITS'($urandom);
    endfunction

    // Mostly beats whose slower estimate sits in the band; the faster one
    // is the other magnitude. One beat in ten is pure noise.
    function automatic sensor_beat_t random_beat(int band);
        sensor_beat_t    b;
        longint unsigned m, other;
        if ($urandom_range(99) < 10) begin
            b.hfi_speed  = SPEED_BITS'($urandom);
            b.flux_speed = SPEED_BITS'($urandom);
        end else begin
            m = band_magnitude(band);
            other = m + $urandom_range(0, $urandom_range(1) ? 32'd1000 : 32'h7FFF_FFFF);
            if (other > SPEED_MAG_MAX)
                other = SPEED_MAG_MAX;
            if ($urandom_range(1)) begin
                b.hfi_speed  = signed_speed(m);
                b.flux_speed = signed_speed(other);
            end else begin
                b.hfi_speed  = signed_speed(other);
                b.flux_speed = signed_speed(m);
            end
        end
        b.hfi_angle  = pick_angle();
        b.flux_angle = pick_angle();
        return b;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] result %0d %s: got 0x%0h, expected 0x%0h",
                     $time, results_seen, field, got, want);
        mismatch_count++;
    endtask

    // Write one register while the block is idle, and mirror it in the shadow copy.
    task automatic set_register(cfg_idx_t idx, logic [THR_BITS-1:0] value);
        cfg_addr  <= idx;
        cfg_wdata <= value;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        case (idx)
            CFG_LOW_SPEED:  thr_low = value;
            CFG_HIGH_SPEED: thr_high = value;
            CFG_DEBOUNCE:   debounce_lim = value[CNT_BITS-1:0];
            CFG_SETTLE:     settle_lim = value[CNT_BITS-1:0];
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one beat, with a random gap in front of it unless no_idle is set,
    // and wait for the handshake. The expectation is worked out once s_tready
    // is back high. Called right after posedge aclk, before s_tvalid is assigned.
    task automatic offer_beat(sensor_beat_t b, bit typed, blend_result_t want);
        blend_result_t predicted;
        if (!no_idle)
            while ($urandom_range(99) < 25) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = predict_blend(b);
        expected_results.push_back(typed ? want : predicted);
    endtask

    // Stop sending and wait until every expected result has been taken.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    // One random phase: program all four registers, then send runs of beats
    // that stay in one speed band long enough for the debounce to play out.
    // Short runs and the noise beats break sequences up.
    task automatic run_phase(longint unsigned lo, longint unsigned hi,
                             int unsigned dbn, int unsigned stl, int count, int style);
        int sent, run_len, band;
        set_register(CFG_LOW_SPEED, THR_BITS'(lo));
        set_register(CFG_HIGH_SPEED, THR_BITS'(hi));
        // Only the low byte counts for the limits; junk above it must be ignored.
        set_register(CFG_DEBOUNCE, THR_BITS'({$urandom, 8'(dbn)}));
        set_register(CFG_SETTLE, THR_BITS'({$urandom, 8'(stl)}));
        no_idle = (style != STYLE_PLAIN);
        if (style == STYLE_HOLD)
            hold_request = 1'b1;
        sent = 0;
        while (sent < count) begin
            band = $urandom_range(BAND_BELOW_LOW, BAND_ANY);
            run_len = $urandom_range(1, debounce_lim + 12);
            for (int k = 0; k < run_len && sent < count; k++) begin
                offer_beat(random_beat(band), 1'b0, '0);
                sent++;
            end
        end
        no_idle = 1'b0;
        wait_all_results();
    endtask

    // Result side: check every accepted beat against the oldest expectation,
    // then decide whether to be ready at the next edge.
    always @(posedge aclk) begin : result_check
        blend_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(blend_result_t)-1:0];
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result beat", got, 0);
            end else begin
                want = expected_results.pop_front();
                if (got.active_mode !== want.active_mode)
                    report_mismatch("active_mode", got.active_mode, want.active_mode);
                if (got.rotor_angle !== want.rotor_angle)
                    report_mismatch("rotor_angle", got.rotor_angle, want.rotor_angle);
                if (got.blend_ratio !== want.blend_ratio)
                    report_mismatch("blend_ratio", got.blend_ratio, want.blend_ratio);
                if (got.use_fundamental !== want.use_fundamental)
                    report_mismatch("use_fundamental", got.use_fundamental,
                                    want.use_fundamental);
                if (got.inject_enable !== want.inject_enable)
                    report_mismatch("inject_enable", got.inject_enable, want.inject_enable);
                if (got.pll_reload !== want.pll_reload)
                    report_mismatch("pll_reload", got.pll_reload, want.pll_reload);
            end
            results_seen++;
        end
        m_tready <= !rx_hold && (no_idle || $urandom_range(99) >= 25);
    end

    // Long receiver hold-off on request. With the sender still offering
    // beats, the output register and the one waiting beat fill up and the
    // block has to drop s_tready.
    initial forever begin
        @(posedge aclk);
        if (hold_request) begin
            hold_request = 1'b0;
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            rx_hold <= 1'b0;
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        // Directed table, run with debounce 0 and settle 1 so that every mode
        // and every special case is reached within a few beats. Rows with an
        // expected result typed in carry values that need no arithmetic.
        directed_table.push_back(dir_row(0, 0, 16'h7FFF, 16'h8000,
            1, MODE_INJ, 16'h7FFF, RATIO_ZERO, 1, 1, 0));
        // Most negative speed: magnitude 2^31, so the flux estimate is the slower one.
        directed_table.push_back(dir_row(32'h8000_0000, SPEED_100, 16'h1234, 16'h0000,
            1, MODE_MIX, 16'h1234, RATIO_ZERO, 1, 1, 0));
        // Settled now: ratio of one half, then a ratio of three quarters
        // with the angle extremes.
        directed_table.push_back(dir_row(SPEED_100, -SPEED_100, 16'd1000, 16'd3000));
        directed_table.push_back(dir_row(SPEED_110, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF));
        directed_table.push_back(dir_row(32'h7FFF_FFFF, 32'h8000_0000, 16'h5555, 16'h8000,
            1, MODE_FLUX, 16'h8000, RATIO_ONE, 0, 0, 0));
        // Speed exactly at the high threshold does not leave flux mode.
        directed_table.push_back(dir_row(SPEED_120, -SPEED_120, 16'h0F0F, 16'd123,
            1, MODE_FLUX, 16'd123, RATIO_ONE, 0, 0, 0));
        // Flux to mixed: reload pulse, and the injection angle is the flux angle.
        directed_table.push_back(dir_row(0, 32'h7FFF_FFFF, -16'sd5, 16'd777,
            1, MODE_MIX, 16'd777, RATIO_ZERO, 1, 1, 1));
        directed_table.push_back(dir_row(SPEED_120, -SPEED_120, 16'h8000, 16'h7FFF));
        directed_table.push_back(dir_row(SPEED_80, SPEED_80, 16'h7FFF, 16'h8000));
        directed_table.push_back(dir_row(SPEED_80 - 1, -SPEED_80, 16'hFFFF, 16'd5,
            1, MODE_INJ, 16'hFFFF, RATIO_ZERO, 1, 1, 0));
        directed_table.push_back(dir_row(-SPEED_80, SPEED_80, 16'h0000, 16'h4000,
            1, MODE_INJ, 16'h0000, RATIO_ZERO, 1, 1, 0));
        // Injection to mixed keeps the settle count, so blending starts at once.
        directed_table.push_back(dir_row(SPEED_80 + 1, SPEED_100, 16'h7FFF, 16'h7FFF));
        // Half-way blends that land exactly on a rounding tie, above and below zero.
        directed_table.push_back(dir_row(SPEED_100, SPEED_100, 16'h0000, 16'h0001));
        directed_table.push_back(dir_row(SPEED_100, SPEED_100, 16'h0000, 16'hFFFF));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_register(CFG_LOW_SPEED, THR_BITS'(SPEED_80));
        set_register(CFG_HIGH_SPEED, THR_BITS'(SPEED_120));
        set_register(CFG_DEBOUNCE, THR_BITS'(0));
        set_register(CFG_SETTLE, THR_BITS'(1));
        foreach (directed_table[i])
            offer_beat(directed_table[i].beat, directed_table[i].typed, directed_table[i].want);
        wait_all_results();

        // Random phases. Each one waits for the last result before the next
        // register write, so the sender pauses until all is delivered.
        run_phase(SPEED_80, SPEED_120, 3, 5, 150, STYLE_PLAIN);
        run_phase(SPEED_80, SPEED_120, 0, 0, 150, STYLE_HOLD);
        // A debounce limit of 255 freezes the mode.
        run_phase($urandom_range(0, 32'd20000000), $urandom_range(0, 32'd20000000),
                  255, $urandom_range(0, 10), 100, STYLE_PLAIN);
        run_phase(0, THR_MAX, 1, 255, 250, STYLE_PLAIN);
        // High threshold below the low one.
        run_phase(SPEED_100, SPEED_50, 2, 1, 150, STYLE_STEADY);
        run_phase(SPEED_90, SPEED_90, 1, 0, 100, STYLE_PLAIN);
        run_phase($urandom_range(0, 32'd20000000), $urandom_range(0, 32'd20000000),
                  $urandom_range(0, 8), $urandom_range(0, 10), 150, STYLE_PLAIN);
        run_phase(LOW_SPEED_RESET, HIGH_SPEED_RESET, DEBOUNCE_RESET, SETTLE_RESET,
                  150, STYLE_PLAIN);

        // Everything has been delivered; watch a little longer for extras.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/smbs_pkg.sv
hdl/sensorless_mode_blend_selector_top.sv
hdl/smbs_checker.sv
sim/tb.sv
